// ----- hdl/linked_block_allocator_macros.svh -----
// Assertion macros for the block allocator checker
`ifndef LINKED_BLOCK_ALLOCATOR_MACROS_SVH
`define LINKED_BLOCK_ALLOCATOR_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define LBA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define LBA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/lba_pkg.sv -----
`default_nettype none

package lba_pkg;

	localparam int BLOCK_W = 6;
	localparam int COUNT_W = 7;
	localparam int ID_W    = 7;
	localparam int CFG_W   = 7;

	typedef logic [1:0]         status_t;
	typedef logic [BLOCK_W-1:0] block_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [ID_W-1:0]    file_id_t;
	typedef logic [CFG_W-1:0]   cfg_t;

	localparam status_t ST_OK          = 2'd0;
	localparam status_t ST_BAD_START   = 2'd1;
	localparam status_t ST_NO_SPACE    = 2'd2;
	localparam status_t ST_TABLE_FULL  = 2'd3;

	localparam cfg_t BLOCKS_IN_USE_RST = 7'd64;

endpackage

`default_nettype wire

// ----- hdl/linked_block_allocator.sv -----
// Channel        | Signals                                       | Handshake
// ---------------+-----------------------------------------------+---------------------------
// request        | start_block, block_count                      | start && !busy
// result         | status, block_number, file_id, last           | valid, one cycle, no stall
// configuration  | cfg_wdata (blocks_in_use)                     | cfg_we
//
// A request takes one check read, one pass over the block map to count free
// blocks, a decision step, and, when more than one block is asked for, a
// claiming pass; both passes are bound by the single read port of the map
// memory. A bad start or a zero count ends after the check; a space or file
// table rejection ends after the decision. After reset, busy stays high while
// the map is cleared. Results cannot be stalled.
`default_nettype none

module linked_block_allocator #(
	parameter int DISK_BLOCKS = 64,
	parameter int MAX_FILES   = 128
) (
	input  wire                logic clk,
	input  wire                logic arst_n,
	input  wire                logic start,
	output                     logic busy,
	input  wire lba_pkg::block_t   start_block,
	input  wire lba_pkg::count_t   block_count,
	input  wire                logic cfg_we,
	input  wire lba_pkg::cfg_t     cfg_wdata,
	output                     logic valid,
	output lba_pkg::status_t       status,
	output lba_pkg::block_t        block_number,
	output lba_pkg::file_id_t      file_id,
	output                     logic last
);

	localparam int AW = $clog2(DISK_BLOCKS);
	localparam int CW = $clog2(DISK_BLOCKS + 1);
	localparam int FW = $clog2(MAX_FILES + 1);
	localparam int NW = (CW > lba_pkg::CFG_W) ? CW : lba_pkg::CFG_W;
	localparam int WW = ((CW > lba_pkg::COUNT_W) ? CW : lba_pkg::COUNT_W) + 1;

	localparam logic [2:0] S_CLR    = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_CHK    = 3'd2;
	localparam logic [2:0] S_COUNT  = 3'd3;
	localparam logic [2:0] S_DECIDE = 3'd4;
	localparam logic [2:0] S_CLAIM  = 3'd5;

	logic [2:0]              state_q;
	logic [AW-1:0]           clr_q;
	logic [CW-1:0]           j_q;
	logic [CW-1:0]           free_q;
	lba_pkg::count_t         k_q;
	logic [FW-1:0]           file_count_q;
	lba_pkg::cfg_t           blocks_in_use_q;
	logic                    v_s1;
	logic                    used_s1;
	logic [AW-1:0]           addr_s1;

	lba_pkg::block_t         start_q;
	lba_pkg::count_t         want_q;
	logic [CW-1:0]           n_q;
	logic                    bad_q;

	logic                    valid_q;
	lba_pkg::status_t        status_q;
	lba_pkg::block_t         block_number_q;
	lba_pkg::file_id_t       file_id_q;
	logic                    last_q;

	logic                    used_mem [DISK_BLOCKS];

	logic [CW-1:0]           managed;
	logic                    accept;
	logic                    issue;
	logic                    claim_hit;
	logic                    enough;
	logic                    files_ok;
	logic                    claim_last;
	logic [AW-1:0]           rd_addr;
	logic                    mem_we;
	logic [AW-1:0]           mem_waddr;
	logic                    mem_wdata;

	logic                    emit;
	lba_pkg::status_t        emit_status;
	lba_pkg::block_t         emit_block;
	lba_pkg::file_id_t       emit_id;
	logic                    emit_last;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	assign managed = (NW'(blocks_in_use_q) > NW'(DISK_BLOCKS)) ? CW'(DISK_BLOCKS)
		: CW'(blocks_in_use_q);

	assign issue      = ((state_q == S_COUNT) || (state_q == S_CLAIM)) && (j_q < n_q);
	assign claim_hit  = (state_q == S_CLAIM) && v_s1 && !used_s1;
	assign enough     = (WW'(free_q) + WW'(1)) >= WW'(want_q);
	assign files_ok   = file_count_q < FW'(MAX_FILES);
	assign claim_last = (k_q + lba_pkg::count_t'(1)) == want_q;

	always_comb begin
		case (state_q)
			S_IDLE:           rd_addr = AW'(start_block);
			S_COUNT, S_CLAIM: rd_addr = j_q[AW-1:0];
			default:          rd_addr = AW'(start_q);
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_s1;
		mem_wdata = 1'b1;
		case (state_q)
			S_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = 1'b0;
			end
			S_DECIDE: begin
				mem_we    = enough && files_ok;
				mem_waddr = AW'(start_q);
			end
			S_CLAIM: begin
				mem_we    = claim_hit;
			end
			default: begin
				mem_we    = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			used_mem[mem_waddr] <= mem_wdata;
		end
		used_s1 <= used_mem[rd_addr];
		addr_s1 <= rd_addr;
	end

	always_comb begin
		emit        = 1'b0;
		emit_status = lba_pkg::ST_OK;
		emit_block  = '0;
		emit_id     = '0;
		emit_last   = 1'b1;
		case (state_q)
			S_CHK: begin
				if (bad_q || used_s1) begin
					emit        = 1'b1;
					emit_status = lba_pkg::ST_BAD_START;
				end else if (want_q == '0) begin
					emit        = 1'b1;
					emit_status = lba_pkg::ST_NO_SPACE;
				end
			end
			S_DECIDE: begin
				emit = 1'b1;
				if (!enough) begin
					emit_status = lba_pkg::ST_NO_SPACE;
				end else if (!files_ok) begin
					emit_status = lba_pkg::ST_TABLE_FULL;
				end else begin
					emit_block = start_q;
					emit_id    = lba_pkg::ID_W'(file_count_q);
					emit_last  = (want_q == lba_pkg::count_t'(1));
				end
			end
			S_CLAIM: begin
				emit       = claim_hit;
				emit_block = lba_pkg::BLOCK_W'(addr_s1);
				emit_id    = lba_pkg::ID_W'(file_count_q);
				emit_last  = claim_last;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_CLR;
			clr_q           <= '0;
			j_q             <= '0;
			free_q          <= '0;
			k_q             <= '0;
			file_count_q    <= '0;
			blocks_in_use_q <= lba_pkg::BLOCKS_IN_USE_RST;
			v_s1            <= 1'b0;
			valid_q         <= 1'b0;
		end else begin
			valid_q <= emit;
			v_s1    <= issue;
			if (cfg_we) begin
				blocks_in_use_q <= cfg_wdata;
			end
			if (issue) begin
				j_q <= j_q + CW'(1);
			end
			if ((state_q == S_COUNT) && v_s1 && !used_s1 && (addr_s1 != AW'(start_q))) begin
				free_q <= free_q + CW'(1);
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DISK_BLOCKS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_CHK;
						free_q  <= '0;
						j_q     <= '0;
					end
				end
				S_CHK: begin
					if (emit) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_COUNT;
					end
				end
				S_COUNT: begin
					if (!issue) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					j_q <= '0;
					k_q <= lba_pkg::count_t'(1);
					if (!enough || !files_ok) begin
						state_q <= S_IDLE;
					end else if (want_q == lba_pkg::count_t'(1)) begin
						file_count_q <= file_count_q + FW'(1);
						state_q      <= S_IDLE;
					end else begin
						state_q <= S_CLAIM;
					end
				end
				S_CLAIM: begin
					if (claim_hit) begin
						k_q <= k_q + lba_pkg::count_t'(1);
						if (claim_last) begin
							file_count_q <= file_count_q + FW'(1);
							state_q      <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			start_q <= start_block;
			want_q  <= block_count;
			n_q     <= managed;
			bad_q   <= NW'(start_block) >= NW'(managed);
		end
		status_q       <= emit_status;
		block_number_q <= emit_block;
		file_id_q      <= emit_id;
		last_q         <= emit_last;
	end

	assign valid        = valid_q;
	assign status       = status_q;
	assign block_number = block_number_q;
	assign file_id      = file_id_q;
	assign last         = last_q;

endmodule

`default_nettype wire

// ----- hdl/lba_checker.sv -----
`default_nettype none
`include "linked_block_allocator_macros.svh"

module lba_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire logic              valid,
	input wire lba_pkg::status_t  status,
	input wire lba_pkg::block_t   block_number,
	input wire lba_pkg::file_id_t file_id,
	input wire logic              last
);

	// a refused transaction gives one result with zeroed fields
	`LBA_ASSERT_NOW(a_reject_single, valid && (status != lba_pkg::ST_OK), last && (block_number == '0) && (file_id == '0), "rejection not a single zeroed result")

	`LBA_ASSERT_NOW(a_chain_busy, valid && !last, busy, "idle while a chain is still open")

	`LBA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")

	`LBA_ASSERT_NEXT(a_last_ends, valid && last, !valid, "result after the final one of a transaction")

endmodule

bind linked_block_allocator lba_checker u_lba_checker (.*);

`default_nettype wire
